// File: src/rabf_pkg.sv
// Shared types and constants for the rotated alpha-blend framebuffer.
// Used by rabf_mix and rotated_alpha_blend_framebuffer_unit; depends on nothing.

package rabf_pkg;

    // Full-scale channel value and alpha weight.
    localparam logic [7:0] CH_MAX     = 8'd255;
    localparam logic [7:0] ALPHA_FULL = 8'hFF;
    localparam logic [7:0] ALPHA_NONE = 8'h00;

    typedef enum logic [1:0] {
        FN_BLEND = 2'd0,
        FN_CLEAR = 2'd1,
        FN_READ  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_ADDR,
        ST_READ,
        ST_FETCH,
        ST_WB,
        ST_RESP,
        ST_CLR
    } state_t;

endpackage

// File: src/rotated_alpha_blend_framebuffer_unit.sv
// Top level of the rotated alpha-blend framebuffer: control sequencer and frame memory.
// Depends on rabf_pkg and rabf_mix.

// The block holds a PANEL_WIDTH x PANEL_HEIGHT RGB888 frame in one synchronous
// memory (one write port, one read port, read data registered) and handles one
// word at a time. A blend passes through coordinate mapping, address multiply,
// memory read, mix, and divide and write back before the next word is accepted;
// a full-alpha overwrite skips the read and mix, and a dropped blend, like a word
// with the unused function code, returns to idle after mapping. A read visits
// mapping, address, memory read and response, or only mapping and response when
// outside the frame, and waits in response while an earlier result holds the
// output register. A clear writes one pixel a cycle and accepts no word until it
// is done. Pixels never written or cleared since reset read back as arbitrary
// values. The rotation register should be written only while the block is idle.

module rotated_alpha_blend_framebuffer_unit
    import rabf_pkg::*;
#(
    parameter int PANEL_WIDTH  = 410,
    parameter int PANEL_HEIGHT = 502
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,    // rotation_quarters
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // x_pos[11:0], y_pos[23:12], colour[47:24], alpha[55:48]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // pixel_colour[23:0]
    output logic        m_axis_tuser    // in_range
);

    localparam int PIXEL_COUNT = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int XW = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
    localparam int YW = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
    localparam int CW = 13;

    localparam logic signed [CW-1:0] W_S   = CW'(PANEL_WIDTH);
    localparam logic signed [CW-1:0] H_S   = CW'(PANEL_HEIGHT);
    localparam logic signed [CW-1:0] WM1_S = CW'(PANEL_WIDTH - 1);
    localparam logic signed [CW-1:0] HM1_S = CW'(PANEL_HEIGHT - 1);
    localparam logic [AW-1:0]        LAST_IDX = AW'(PIXEL_COUNT - 1);
    localparam logic [AW-1:0]        IDX_W    = AW'(PANEL_WIDTH);

    state_t         state_reg, state_next;
    rot_t           rot_reg;
    logic [1:0]     func_reg;
    logic [11:0]    x_reg, y_reg;
    logic [23:0]    colour_reg;
    logic [7:0]     alpha_reg;
    logic [XW-1:0]  px_reg;
    logic [YW-1:0]  py_reg;
    logic           hit_reg;
    logic [AW-1:0]  idx_reg;
    logic [AW-1:0]  clear_index_reg, clear_index_next;
    logic [23:0]    rd_data_reg;
    logic           out_valid_reg;
    logic [23:0]    out_pixel_reg;
    logic           out_in_range_reg;

    logic [23:0]    frame_mem [PIXEL_COUNT];

    logic                 in_accept;
    logic signed [CW-1:0] xs, ys, px, py;
    logic                 hit;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        wr_addr;
    logic [23:0]          wr_data;
    logic                 mix_load;
    logic [23:0]          mix_out;
    logic                 out_load;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;
    assign m_axis_tuser  = out_in_range_reg;

    rabf_mix u_mix (
        .clk       (clk),
        .load      (mix_load),
        .colour    (colour_reg),
        .old_pixel (rd_data_reg),
        .alpha     (alpha_reg),
        .mixed     (mix_out)
    );

    // Logical to physical coordinates; reads use the physical position as given.
    always_comb
    begin
        xs = CW'(signed'(x_reg));
        ys = CW'(signed'(y_reg));
        px = xs;
        py = ys;
        if (func_reg == FN_BLEND)
        begin
            unique case (rot_reg)
                ROT_0:
                begin
                    px = xs;
                    py = ys;
                end
                ROT_90:
                begin
                    px = WM1_S - ys;
                    py = xs;
                end
                ROT_180:
                begin
                    px = WM1_S - xs;
                    py = HM1_S - ys;
                end
                ROT_270:
                begin
                    px = ys;
                    py = HM1_S - xs;
                end
                default:
                begin
                    px = xs;
                    py = ys;
                end
            endcase
        end
        hit = (px >= 0) && (py >= 0) && (px < W_S) && (py < H_S);
    end

    always_comb
    begin
        state_next       = state_reg;
        clear_index_next = clear_index_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        wr_addr          = idx_reg;
        wr_data          = (alpha_reg == ALPHA_FULL) ? colour_reg : mix_out;
        mix_load         = 1'b0;
        out_load         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_MAP;
            end
            ST_MAP:
            begin
                unique case (func_reg)
                    FN_BLEND:
                        state_next = (hit && alpha_reg != ALPHA_NONE) ? ST_ADDR : ST_IDLE;
                    FN_READ:
                        state_next = hit ? ST_ADDR : ST_RESP;
                    FN_CLEAR:
                        state_next = ST_CLR;
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_ADDR:
            begin
                if (func_reg == FN_BLEND && alpha_reg == ALPHA_FULL)
                    state_next = ST_WB;
                else
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = (func_reg == FN_READ) ? ST_RESP : ST_FETCH;
            end
            ST_FETCH:
            begin
                mix_load   = 1'b1;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                mem_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                mem_we  = 1'b1;
                wr_addr = clear_index_reg;
                wr_data = colour_reg;
                if (clear_index_reg == LAST_IDX)
                begin
                    clear_index_next = '0;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    clear_index_next = clear_index_reg + AW'(1);
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rot_reg         <= ROT_0;
            clear_index_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clear_index_reg <= clear_index_next;
            if (cfg_wr_en)
                rot_reg <= rot_t'(cfg_wr_data);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg   <= s_axis_tuser;
            x_reg      <= s_axis_tdata[11:0];
            y_reg      <= s_axis_tdata[23:12];
            colour_reg <= s_axis_tdata[47:24];
            alpha_reg  <= s_axis_tdata[55:48];
        end
        if (state_reg == ST_MAP)
        begin
            px_reg  <= px[XW-1:0];
            py_reg  <= py[YW-1:0];
            hit_reg <= hit;
        end
        if (state_reg == ST_ADDR)
            idx_reg <= AW'(AW'(py_reg) * IDX_W) + AW'(px_reg);
        if (out_load)
        begin
            out_pixel_reg    <= hit_reg ? rd_data_reg : 24'd0;
            out_in_range_reg <= hit_reg;
        end
    end

    // Frame memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_data_reg <= frame_mem[idx_reg];
    end

`ifndef ASSERT_OFF
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_WB || state_reg == ST_CLR))
        else $error("frame memory written outside write-back or clear");

    a_clear_index_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_CLR |-> clear_index_reg == '0)
        else $error("clear walk counter not at zero outside a clear");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_RESP && $past(func_reg) == FN_READ)
        else $error("result word produced by something other than a read");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == 24'd0)
        else $error("out-of-range read returned a non-zero pixel");
`endif

endmodule

// File: src/rabf_mix.sv
// Per-channel alpha mixer: (c*a + old*(255-a))/255, truncated, for RGB888.
// One register stage holds the weighted sums; the divide by 255 follows it.
// Depends on rabf_pkg.

module rabf_mix
    import rabf_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic [23:0] colour,
    input  logic [23:0] old_pixel,
    input  logic [7:0]  alpha,
    output logic [23:0] mixed
);

    logic [15:0] sum_reg [3];
    logic [7:0]  inv_alpha;

    assign inv_alpha = CH_MAX - alpha;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                sum_reg[ch] <= 16'(colour[ch*8 +: 8] * alpha)
                             + 16'(old_pixel[ch*8 +: 8] * inv_alpha);
            end
        end
    end

    // The sum never exceeds 255*255, where (s + s/256 + 1)/256 equals s/255 exactly.
    always_comb
    begin
        logic [16:0] adj;
        for (int ch = 0; ch < 3; ch++)
        begin
            adj = 17'(sum_reg[ch]) + 17'(sum_reg[ch][15:8]) + 17'd1;
            mixed[ch*8 +: 8] = adj[15:8];
        end
    end

endmodule
